>>> hw/rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg: shared types and constants of the polyline rectangle clipper
// Holds the coordinate, point and configuration types and the stage codes.
// ----------------------------------------------------------------------------
package prc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CW          = COORD_WIDTH;
    localparam int DW          = CW + 1;      // width of a coordinate difference
    localparam int PW          = 2 * DW;      // width of a difference product
    localparam int FQ_DEPTH    = 4;           // front-to-back queue depth

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [DW-1:0] diff_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        point_t pt;
        logic   final_flag;
    } vtx_t;

    typedef struct packed {
        coord_t x_min;
        coord_t y_min;
        coord_t x_max;
        coord_t y_max;
    } clip_cfg_t;

    typedef enum logic [1:0] {
        REG_X_MIN = 2'd0,
        REG_Y_MIN = 2'd1,
        REG_X_MAX = 2'd2,
        REG_Y_MAX = 2'd3
    } cfg_idx_t;

    // Request to the intersection unit: base + d*n/den, truncated toward zero.
    typedef struct packed {
        coord_t base;
        diff_t  d;
        diff_t  n;
        diff_t  den;
    } isect_req_t;

    localparam logic [2:0] STG_LEFT   = 3'd0;
    localparam logic [2:0] STG_RIGHT  = 3'd1;
    localparam logic [2:0] STG_BOTTOM = 3'd2;
    localparam logic [2:0] STG_TOP    = 3'd3;
    localparam logic [2:0] STG_DEDUP  = 3'd4;

    function automatic diff_t sx(coord_t v);
        return {v[CW-1], v};
    endfunction

endpackage

>>> hw/rtl/prc_front.sv
// ----------------------------------------------------------------------------
// prc_front: input side of the clipper
// Accepts vertices and queues them, tagged with their end-of-run flag.
// ----------------------------------------------------------------------------
module prc_front import prc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  vtx_t s_vtx,
    output logic q_valid,
    input  logic q_pop,
    output vtx_t q_vtx
);

    localparam int AW = $clog2(FQ_DEPTH);

    vtx_t             mem_reg [FQ_DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push, pop;

    assign s_ready = (count_reg != (AW+1)'(FQ_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_vtx   = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_vtx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> hw/rtl/prc_isect.sv
// ----------------------------------------------------------------------------
// prc_isect: edge intersection unit
// A multiply step, then a bit-serial restoring division, then the offset.
// ----------------------------------------------------------------------------
module prc_isect import prc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  isect_req_t req,
    output logic       done,
    output coord_t     result
);

    localparam int CNTW = $clog2(PW);

    typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV, D_FIX} dstate_t;

    dstate_t           state_reg;
    logic [DW-1:0]     mag_d_reg, mag_n_reg, mag_den_reg;
    logic              neg_reg;
    coord_t            base_reg;
    logic [PW-1:0]     prod_reg;
    logic [DW:0]       rem_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              done_reg;
    coord_t            result_reg;
    logic [DW:0]       rem_shift;
    logic [DW:0]       base_ext, q_ext;

    assign rem_shift = {rem_reg[DW-1:0], prod_reg[PW-1]};
    assign base_ext  = {base_reg[CW-1], base_reg[CW-1], base_reg};
    assign q_ext     = {1'b0, prod_reg[DW-1:0]};
    assign done      = done_reg;
    assign result    = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE: begin
                    if (start) begin
                        mag_d_reg   <= req.d[DW-1]   ? DW'(-req.d)   : DW'(req.d);
                        mag_n_reg   <= req.n[DW-1]   ? DW'(-req.n)   : DW'(req.n);
                        mag_den_reg <= req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
                        neg_reg     <= req.d[DW-1] ^ req.n[DW-1] ^ req.den[DW-1];
                        base_reg    <= req.base;
                        state_reg   <= D_MUL;
                    end
                end
                D_MUL: begin
                    prod_reg  <= mag_d_reg * mag_n_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= CNTW'(PW - 1);
                    state_reg <= D_DIV;
                end
                D_DIV: begin
                    if (rem_shift >= {1'b0, mag_den_reg}) begin
                        rem_reg  <= rem_shift - {1'b0, mag_den_reg};
                        prod_reg <= {prod_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_reg  <= rem_shift;
                        prod_reg <= {prod_reg[PW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) state_reg <= D_FIX;
                end
                D_FIX: begin
                    // A zero quotient makes the sign irrelevant.
                    result_reg <= neg_reg ? coord_t'(base_ext - q_ext)
                                          : coord_t'(base_ext + q_ext);
                    done_reg   <= 1'b1;
                    state_reg  <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

endmodule

>>> hw/rtl/prc_back.sv
// ----------------------------------------------------------------------------
// prc_back: clipping sequencer
// Runs the left, right, bottom and top edge stages depth first, removes
// repeated points, and holds the result register.
// ----------------------------------------------------------------------------
module prc_back import prc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  clip_cfg_t cfg,
    input  logic      q_valid,
    output logic      q_pop,
    input  vtx_t      q_vtx,
    output logic      m_valid,
    input  logic      m_ready,
    output coord_t    m_x,
    output coord_t    m_y,
    output logic      m_present,
    output logic      m_end
);

    typedef enum logic [2:0] {S_IDLE, S_STEP, S_WAIT, S_NEXT, S_FIN} state_t;

    state_t       state_reg;
    point_t       wp_reg;
    logic [2:0]   ts_reg;
    logic [2:0]   end_idx_reg;
    logic         fin_reg;

    point_t       first_in_reg [4];
    point_t       prev_reg [4];
    point_t       first_out_reg [4];
    point_t       last_out_reg [4];
    logic [3:0]   inside_reg, started_reg;
    logic [1:0]   cnt_reg [4];
    point_t       pend_reg [4][2];
    logic [1:0]   pend_cnt_reg [4];
    point_t       last_kept_reg;
    logic         any_kept_reg;

    logic         m_valid_reg, m_present_reg, m_end_reg;
    coord_t       m_x_reg, m_y_reg;

    logic [1:0]   s2, e2, hi;
    logic         any_pend;
    coord_t       edge_val;
    logic         pin, need_x, out_free, out_load, end_ok;
    point_t       pv, ip, o0, o1;
    logic [1:0]   ap_n, base_cnt;
    logic [2:0]   cnt_sum;
    isect_req_t   req;
    logic         div_start, div_done;
    coord_t       div_res;

    assign s2       = ts_reg[1:0];
    assign e2       = end_idx_reg[1:0];
    assign pv       = prev_reg[s2];
    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid;

    // A new result is loaded into the output register in this cycle.
    assign out_load = out_free &&
                      ((((state_reg == S_STEP) || (state_reg == S_WAIT)) &&
                        (ts_reg == STG_DEDUP) && any_kept_reg &&
                        (wp_reg != last_kept_reg)) ||
                       (state_reg == S_FIN));

    always_comb begin
        case (ts_reg)
            STG_LEFT:   begin edge_val = cfg.x_min; pin = (wp_reg.x >= cfg.x_min); end
            STG_RIGHT:  begin edge_val = cfg.x_max; pin = (wp_reg.x <= cfg.x_max); end
            STG_BOTTOM: begin edge_val = cfg.y_min; pin = (wp_reg.y >= cfg.y_min); end
            default:    begin edge_val = cfg.y_max; pin = (wp_reg.y <= cfg.y_max); end
        endcase
    end

    assign need_x = started_reg[s2] && (inside_reg[s2] != pin);

    always_comb begin
        if (!ts_reg[1]) begin
            req.base = pv.y;
            req.d    = sx(wp_reg.y) - sx(pv.y);
            req.n    = sx(edge_val) - sx(pv.x);
            req.den  = sx(wp_reg.x) - sx(pv.x);
            ip       = '{x: edge_val, y: div_res};
        end else begin
            req.base = pv.x;
            req.d    = sx(wp_reg.x) - sx(pv.x);
            req.n    = sx(edge_val) - sx(pv.y);
            req.den  = sx(wp_reg.y) - sx(pv.y);
            ip       = '{x: div_res, y: edge_val};
        end
    end

    assign div_start = (state_reg == S_STEP) && (ts_reg != STG_DEDUP) && need_x;

    // Outputs a stage gives for the current point.
    always_comb begin
        o0   = wp_reg;
        o1   = wp_reg;
        ap_n = 2'd0;
        if (!started_reg[s2]) begin
            ap_n = pin ? 2'd1 : 2'd0;
        end else if (inside_reg[s2]) begin
            ap_n = 2'd1;
            if (!pin) o0 = ip;
        end else if (pin) begin
            ap_n = 2'd2;
            o0   = ip;
        end
        base_cnt = started_reg[s2] ? cnt_reg[s2] : 2'd0;
        cnt_sum  = {1'b0, base_cnt} + {1'b0, ap_n};
    end

    always_comb begin
        any_pend = 1'b1;
        if (pend_cnt_reg[3] != 2'd0)      hi = 2'd3;
        else if (pend_cnt_reg[2] != 2'd0) hi = 2'd2;
        else if (pend_cnt_reg[1] != 2'd0) hi = 2'd1;
        else begin
            hi       = 2'd0;
            any_pend = (pend_cnt_reg[0] != 2'd0);
        end
    end

    // Closing append of a stage at the end of a run.
    assign end_ok = started_reg[e2] && (cnt_reg[e2] == 2'd2)
                    && (first_in_reg[e2] == prev_reg[e2])
                    && (first_out_reg[e2] != last_out_reg[e2]);

    prc_isect u_isect (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .req     (req),
        .done    (div_done),
        .result  (div_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid_reg  <= 1'b0;
            started_reg  <= '0;
            inside_reg   <= '0;
            any_kept_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                cnt_reg[i]      <= '0;
                pend_cnt_reg[i] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && !out_load) m_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        wp_reg      <= q_vtx.pt;
                        fin_reg     <= q_vtx.final_flag;
                        ts_reg      <= STG_LEFT;
                        end_idx_reg <= STG_LEFT;
                        state_reg   <= S_STEP;
                    end
                end
                S_STEP, S_WAIT: begin
                    if (ts_reg == STG_DEDUP) begin
                        if (any_kept_reg && (wp_reg == last_kept_reg)) begin
                            state_reg <= S_NEXT;
                        end else if (!any_kept_reg || out_free) begin
                            if (any_kept_reg) begin
                                m_valid_reg   <= 1'b1;
                                m_x_reg       <= last_kept_reg.x;
                                m_y_reg       <= last_kept_reg.y;
                                m_present_reg <= 1'b1;
                                m_end_reg     <= 1'b0;
                            end
                            last_kept_reg <= wp_reg;
                            any_kept_reg  <= 1'b1;
                            state_reg     <= S_NEXT;
                        end
                    end else if (state_reg == S_STEP && need_x) begin
                        state_reg <= S_WAIT;
                    end else if (state_reg == S_STEP || div_done) begin
                        started_reg[s2] <= 1'b1;
                        if (!started_reg[s2]) first_in_reg[s2] <= wp_reg;
                        prev_reg[s2]     <= wp_reg;
                        inside_reg[s2]   <= pin;
                        pend_reg[s2][0]  <= o0;
                        pend_reg[s2][1]  <= o1;
                        pend_cnt_reg[s2] <= ap_n;
                        if (ap_n != 2'd0) begin
                            if (base_cnt == 2'd0) first_out_reg[s2] <= o0;
                            last_out_reg[s2] <= (ap_n == 2'd2) ? o1 : o0;
                            cnt_reg[s2]      <= (cnt_sum >= 3'd2) ? 2'd2 : cnt_sum[1:0];
                        end else begin
                            cnt_reg[s2] <= base_cnt;
                        end
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (any_pend) begin
                        wp_reg           <= pend_reg[hi][0];
                        pend_reg[hi][0]  <= pend_reg[hi][1];
                        pend_cnt_reg[hi] <= pend_cnt_reg[hi] - 1'b1;
                        ts_reg           <= {1'b0, hi} + 3'd1;
                        state_reg        <= S_STEP;
                    end else if (!fin_reg) begin
                        state_reg <= S_IDLE;
                    end else if (end_idx_reg == STG_DEDUP) begin
                        state_reg <= S_FIN;
                    end else begin
                        if (end_ok) begin
                            pend_reg[e2][0]  <= first_out_reg[e2];
                            pend_cnt_reg[e2] <= 2'd1;
                            last_out_reg[e2] <= first_out_reg[e2];
                        end
                        end_idx_reg <= end_idx_reg + 3'd1;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_x_reg       <= any_kept_reg ? last_kept_reg.x : '0;
                        m_y_reg       <= any_kept_reg ? last_kept_reg.y : '0;
                        m_present_reg <= any_kept_reg;
                        m_end_reg     <= 1'b1;
                        started_reg   <= '0;
                        inside_reg    <= '0;
                        any_kept_reg  <= 1'b0;
                        for (int i = 0; i < 4; i++) cnt_reg[i] <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_x       = m_x_reg;
    assign m_y       = m_y_reg;
    assign m_present = m_present_reg;
    assign m_end     = m_end_reg;

    // No stage ever holds more than two points waiting for the next stage.
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg[0] != 2'd3 && pend_cnt_reg[1] != 2'd3 &&
        pend_cnt_reg[2] != 2'd3 && pend_cnt_reg[3] != 2'd3)
        else $error("stage pending count out of range");

    // Nothing is left waiting between stages once the sequencer goes idle.
    a_idle_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !any_pend)
        else $error("points left pending while idle");

    // The end-of-run transfer leaves the duplicate filter and stages cleared.
    a_run_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FIN && out_free) |=> (!any_kept_reg && started_reg == '0))
        else $error("state not cleared after end of run");

endmodule

>>> hw/rtl/polyline_rect_clipper.sv
// ----------------------------------------------------------------------------
// polyline_rect_clipper: clips polyline vertices against a rectangle
// Top level with the configuration registers, the front queue and the back
// sequencer.
// ----------------------------------------------------------------------------
// Usage:
// Vertices enter on the s_ channel, one transfer per vertex; s_vertex_final
// marks the last vertex of a polyline. Clipped vertices leave on the m_
// channel; m_run_end marks the last result of a polyline, and a polyline
// with no surviving point yields one transfer with m_point_present low and
// zero coordinates. Clip rectangle edges are written on the cfg_ channel
// (always ready) while the block is idle, by the user; the block does not
// enforce it. Vertices wait in a four deep queue. The back end takes a vertex
// from the queue only when it is done with the last one, handles each point
// stage by stage, and sends every edge intersection through the one shared
// multiply and bit-serial divide unit. A point is held back until the next
// distinct point or the end of the run so that it can carry m_run_end.
// Reset clears the queue, the stage state and the result valid flag and loads
// the default rectangle 0..1023 by 0..767. A stalled receiver holds the
// result register; the sequencer waits and the queue fills before s_ready
// drops.
// ----------------------------------------------------------------------------
module polyline_rect_clipper import prc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  coord_t        s_vertex_x,
    input  coord_t        s_vertex_y,
    input  logic          s_vertex_final,
    output logic          m_valid,
    input  logic          m_ready,
    output coord_t        m_clipped_x,
    output coord_t        m_clipped_y,
    output logic          m_point_present,
    output logic          m_run_end,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  coord_t        cfg_data
);

    clip_cfg_t cfg_reg;
    vtx_t      s_vtx, q_vtx;
    logic      q_valid, q_pop;

    assign cfg_ready = 1'b1;

    // Clip rectangle registers; every index of the port maps to one edge.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_min <= coord_t'(0);
            cfg_reg.y_min <= coord_t'(0);
            cfg_reg.x_max <= coord_t'(1023);
            cfg_reg.y_max <= coord_t'(767);
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_X_MIN: cfg_reg.x_min <= cfg_data;
                REG_Y_MIN: cfg_reg.y_min <= cfg_data;
                REG_X_MAX: cfg_reg.x_max <= cfg_data;
                REG_Y_MAX: cfg_reg.y_max <= cfg_data;
                default:   cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s_vtx = '{pt: '{x: s_vertex_x, y: s_vertex_y}, final_flag: s_vertex_final};

    prc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_vtx   (s_vtx),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .q_vtx   (q_vtx)
    );

    prc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_vtx     (q_vtx),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_x       (m_clipped_x),
        .m_y       (m_clipped_y),
        .m_present (m_point_present),
        .m_end     (m_run_end)
    );

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the polyline rectangle clipper
// Streams polylines through the clipper under several clip rectangles and
// flow-control patterns. A scoreboard class predicts every clipped vertex
// and compares each result transfer against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import prc_pkg::*;

typedef struct {
    longint x;
    longint y;
} xy_t;

typedef struct {
    coord_t x;
    coord_t y;
    logic   present;
    logic   last;
} clip_result_t;

class clip_scoreboard;
    longint       x_min, y_min, x_max, y_max;
    xy_t          first_in[4], prev_in[4], first_out[4], last_out[4];
    bit           in_zone[4], started[4];
    int unsigned  out_count[4];
    xy_t          kept;
    bit           any_kept;
    clip_result_t expected_q[$];
    int           errors;
    int           results_seen;
    int           markers_seen;

    function new();
        x_min = 0;
        y_min = 0;
        x_max = 1023;
        y_max = 767;
        errors = 0;
        results_seen = 0;
        markers_seen = 0;
        clear_run();
    endfunction

    function void clear_run();
        xy_t z;
        z.x = 0;
        z.y = 0;
        for (int s = 0; s < 4; s++) begin
            first_in[s] = z;
            prev_in[s] = z;
            first_out[s] = z;
            last_out[s] = z;
            in_zone[s] = 0;
            started[s] = 0;
            out_count[s] = 0;
        end
        kept = z;
        any_kept = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, coord_t value);
        case (idx)
            REG_X_MIN: x_min = value;
            REG_Y_MIN: y_min = value;
            REG_X_MAX: x_max = value;
            REG_Y_MAX: y_max = value;
        endcase
    endfunction

    function void add_result(xy_t p, bit present, bit last);
        clip_result_t r;
        r.x = coord_t'(p.x);
        r.y = coord_t'(p.y);
        r.present = present;
        r.last = last;
        expected_q.push_back(r);
    endfunction

    function bit is_inside(int s, xy_t p);
        case (s)
            0: return p.x >= x_min;
            1: return p.x <= x_max;
            2: return p.y >= y_min;
            default: return p.y <= y_max;
        endcase
    endfunction

    // SystemVerilog division truncates toward zero, which is what the edge
    // intersection needs; the product fits easily in 64 bits.
    function xy_t edge_cross(int s, xy_t a, xy_t c);
        xy_t    r;
        longint e;
        if (s < 2) begin
            e = (s == 0) ? x_min : x_max;
            r.x = e;
            r.y = (c.x == a.x) ? a.y : a.y + ((c.y - a.y) * (e - a.x)) / (c.x - a.x);
        end else begin
            e = (s == 2) ? y_min : y_max;
            r.y = e;
            r.x = (c.y == a.y) ? a.x : a.x + ((c.x - a.x) * (e - a.y)) / (c.y - a.y);
        end
        return r;
    endfunction

    function void keep_point(xy_t p);
        if (any_kept) begin
            if (p.x == kept.x && p.y == kept.y)
                return;
            add_result(kept, 1, 0);
        end
        kept = p;
        any_kept = 1;
    endfunction

    function void stage_emit(int s, xy_t q);
        if (out_count[s] == 0)
            first_out[s] = q;
        last_out[s] = q;
        if (out_count[s] < 2)
            out_count[s]++;
        feed_stage(s + 1, q);
    endfunction

    function void feed_stage(int s, xy_t p);
        bit in;
        if (s >= 4) begin
            keep_point(p);
            return;
        end
        in = is_inside(s, p);
        if (!started[s]) begin
            started[s] = 1;
            first_in[s] = p;
            prev_in[s] = p;
            out_count[s] = 0;
            in_zone[s] = in;
            if (in)
                stage_emit(s, p);
            return;
        end
        if (in_zone[s]) begin
            if (in) begin
                stage_emit(s, p);
            end else begin
                stage_emit(s, edge_cross(s, prev_in[s], p));
                in_zone[s] = 0;
            end
        end else if (in) begin
            stage_emit(s, edge_cross(s, prev_in[s], p));
            stage_emit(s, p);
            in_zone[s] = 1;
        end
        prev_in[s] = p;
    endfunction

    // Called for each accepted vertex transfer.
    function void note_vertex(coord_t vx, coord_t vy, logic fin);
        xy_t p;
        xy_t z;
        p.x = vx;
        p.y = vy;
        z.x = 0;
        z.y = 0;
        feed_stage(0, p);
        if (fin) begin
            // A closed input whose output did not come back to its start
            // gets its first output appended.
            for (int s = 0; s < 4; s++) begin
                if (started[s] && out_count[s] >= 2 &&
                    first_in[s].x == prev_in[s].x && first_in[s].y == prev_in[s].y &&
                    (first_out[s].x != last_out[s].x || first_out[s].y != last_out[s].y))
                    stage_emit(s, first_out[s]);
            end
            if (any_kept)
                add_result(kept, 1, 1);
            else
                add_result(z, 0, 1);
            clear_run();
        end
    endfunction

    // Called for each accepted result transfer.
    function void check_result(coord_t rx, coord_t ry, logic present, logic last);
        clip_result_t e;
        results_seen++;
        if (!present)
            markers_seen++;
        if (expected_q.size() == 0) begin
            $error("unexpected result x=%0d y=%0d present=%0b end=%0b", rx, ry, present, last);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (rx !== e.x) begin
            $error("clipped_x: expected %0d, got %0d", e.x, rx);
            errors++;
        end
        if (ry !== e.y) begin
            $error("clipped_y: expected %0d, got %0d", e.y, ry);
            errors++;
        end
        if (present !== e.present) begin
            $error("point_present: expected %0b, got %0b", e.present, present);
            errors++;
        end
        if (last !== e.last) begin
            $error("run_end: expected %0b, got %0b", e.last, last);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module testbench;

    logic   aclk;
    logic   aresetn;
    logic   s_valid;
    logic   s_ready;
    coord_t s_vertex_x;
    coord_t s_vertex_y;
    logic   s_vertex_final;
    logic   m_valid;
    logic   m_ready;
    coord_t m_clipped_x;
    coord_t m_clipped_y;
    logic   m_point_present;
    logic   m_run_end;
    logic   cfg_valid;
    logic   cfg_ready;
    logic [1:0] cfg_index;
    coord_t cfg_data;

    clip_scoreboard sb;

    // Flow-control knobs, changed per phase by the main sequence.
    int send_gap_pct;
    int recv_stall_pct;
    int hold_left;
    int vertices_sent;
    int polylines_sent;

    // The current rectangle, used to aim random vertices near its edges.
    int rect_xl, rect_yl, rect_xh, rect_yh;

    polyline_rect_clipper u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_vertex_x      (s_vertex_x),
        .s_vertex_y      (s_vertex_y),
        .s_vertex_final  (s_vertex_final),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_clipped_x     (m_clipped_x),
        .m_clipped_y     (m_clipped_y),
        .m_point_present (m_point_present),
        .m_run_end       (m_run_end),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("timeout waiting for results");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Monitor: both channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands, so a transfer is seen exactly
    // once with the payload that was actually handed over.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_vertex(s_vertex_x, s_vertex_y, s_vertex_final);
            if (m_valid && m_ready)
                sb.check_result(m_clipped_x, m_clipped_y, m_point_present, m_run_end);
        end
    end

    // Receiver: random stalls, or a long counted hold-off when requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Sends one vertex. Entered right after a rising edge; returns right
    // after the edge at which the vertex transfer took place.
    task automatic send_vertex(int vx, int vy, bit fin);
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_vertex_x     <= coord_t'(vx);
        s_vertex_y     <= coord_t'(vy);
        s_vertex_final <= fin;
        do @(posedge aclk); while (!s_ready);
        vertices_sent++;
        if (fin)
            polylines_sent++;
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= coord_t'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, coord_t'(value));
    endtask

    task automatic set_rect(int xl, int yl, int xh, int yh);
        write_reg(REG_X_MIN, xl);
        write_reg(REG_Y_MIN, yl);
        write_reg(REG_X_MAX, xh);
        write_reg(REG_Y_MAX, yh);
        rect_xl = xl;
        rect_yl = yl;
        rect_xh = xh;
        rect_yh = yh;
    endtask

    // The sender stops, every expected result is collected, and then the
    // block gets time to settle before the rectangle may change.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    // A coordinate near the span lo..hi, reaching some way past both ends,
    // or now and then any 16-bit value at all.
    function automatic int pick_coord(int lo, int hi);
        int a, b, span, v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        if ($urandom_range(99) < 20)
            return int'(coord_t'($urandom));
        span = b - a + 20;
        v = a - span + int'($urandom_range(3 * span));
        if (v < -32768)
            v = -32768;
        if (v > 32767)
            v = 32767;
        return v;
    endfunction

    task automatic random_polyline();
        int n, fx, fy, x, y;
        bit closed;
        n = $urandom_range(7, 1);
        closed = ($urandom_range(99) < 40);
        fx = pick_coord(rect_xl, rect_xh);
        fy = pick_coord(rect_yl, rect_yh);
        x = fx;
        y = fy;
        send_vertex(fx, fy, (n == 1) && !closed);
        for (int i = 1; i < n; i++) begin
            // Repeat the previous vertex now and then to hit the duplicate filter.
            if ($urandom_range(99) >= 10) begin
                x = pick_coord(rect_xl, rect_xh);
                y = pick_coord(rect_yl, rect_yh);
            end
            send_vertex(x, y, (i == n - 1) && !closed);
        end
        if (closed)
            send_vertex(fx, fy, 1'b1);
    endtask

    task automatic random_polylines(int count);
        for (int i = 0; i < count; i++)
            random_polyline();
    endtask

    initial begin
        sb = new();
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_vertex_x     <= '0;
        s_vertex_y     <= '0;
        s_vertex_final <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_X_MIN;
        cfg_data       <= '0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        vertices_sent  = 0;
        polylines_sent = 0;
        rect_xl = 0;
        rect_yl = 0;
        rect_xh = 1023;
        rect_yh = 767;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Directed part on the reset rectangle, no idling.
        send_vertex(10, 10, 1);                          // lone inside point
        send_vertex(-5, 10, 1);                          // lone outside point: empty marker
        send_vertex(-32768, -32768, 0);                  // diagonal through all edges
        send_vertex(32767, 32767, 1);
        send_vertex(32767, -32768, 0);
        send_vertex(-32768, 32767, 1);
        send_vertex(-100, -100, 0);                      // closed square around the rectangle
        send_vertex(1200, -100, 0);
        send_vertex(1200, 900, 0);
        send_vertex(-100, 900, 0);
        send_vertex(-100, -100, 1);
        send_vertex(5, 5, 0);                            // consecutive duplicates
        send_vertex(5, 5, 0);
        send_vertex(6, 6, 1);
        send_vertex(500, -50, 0);                        // closed triangle cut by bottom edge
        send_vertex(900, 400, 0);
        send_vertex(100, 400, 0);
        send_vertex(500, -50, 1);
        send_vertex(0, 767, 0);                          // points lying on edges
        send_vertex(1023, 0, 0);
        send_vertex(2000, 300, 0);                       // leave and come back
        send_vertex(300, 300, 1);
        random_polylines(8);
        drain();

        // Random rectangle, sender idling.
        set_rect($urandom_range(400), $urandom_range(300),
                 500 + $urandom_range(800), 400 + $urandom_range(600));
        send_gap_pct = 52;
        random_polylines(10);
        drain();

        // Full coordinate range, receiver stalling plus a long hold-off
        // while the sender keeps offering vertices.
        set_rect(-32768, -32768, 32767, 32767);
        send_gap_pct = 0;
        recv_stall_pct = 52;
        hold_left = 400;
        random_polylines(10);
        drain();

        // Crossed edges: every polyline clips to nothing.
        set_rect(300, 200, -300, -200);
        recv_stall_pct = 13;
        send_gap_pct = 13;
        send_vertex(0, 0, 0);
        send_vertex(100, 100, 1);
        random_polylines(6);
        drain();

        // Zero-width and zero-height rectangle.
        set_rect(-7, 12, -7, 12);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        send_vertex(-7, 12, 1);
        send_vertex(-20, 0, 0);
        send_vertex(10, 30, 1);
        random_polylines(6);
        drain();

        // Narrow rectangle near the negative corner, with both sides idling.
        set_rect(-32768, -32768, -32000, -32100);
        send_gap_pct = 13;
        recv_stall_pct = 13;
        random_polylines(8);
        drain();

        $display("covered %0d vertices in %0d polylines over six clip rectangles",
                 vertices_sent, polylines_sent);
        $display("checked %0d results, %0d of them empty-run markers",
                 sb.results_seen, sb.markers_seen);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/prc_pkg.sv
hw/rtl/prc_front.sv
hw/rtl/prc_isect.sv
hw/rtl/prc_back.sv
hw/rtl/polyline_rect_clipper.sv
test/testbench.sv
